[sv/pcx_rle_decoder_macros.svh]
// Assertion macros shared by the PCX run-length decoder modules.
`ifndef PCX_RLE_DECODER_MACROS_SVH
`define PCX_RLE_DECODER_MACROS_SVH

// Same-cycle implication, checked on clk, masked while rst_n is low.
`define PCX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, masked while rst_n is low.
`define PCX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pcxrle_pkg.sv]
// Shared types and constants of the PCX run-length decoder.
`timescale 1ns / 1ps

package pcxrle_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned RUN_W  = 6;
  localparam int unsigned CNT_W  = 21;
  localparam int unsigned IDX_W  = 20;

  // Count byte marker and run length field
  localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;
  localparam logic [BYTE_W-1:0] RUN_MASK = 8'h3F;

  localparam logic [CNT_W-1:0] IMG_PIX_RESET = 21'd64000;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // take the input beat
    logic emit;    // load one pixel into the output register
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic start_run;  // accepted beat opens a non-empty run
    logic emit_last;  // pixel being emitted ends the run
    logic slot_free;  // output register can take a pixel this cycle
  } dp_sts_t;

endpackage

[sv/pcx_rle_decoder.sv]
// Top level of the PCX run-length decoder: controller plus datapath.
//
// Usage:
//   in_*  : one compressed PCX pixel byte per beat (in_tdata[7:0]).
//   out_* : one decoded pixel per beat; out_tdata holds the pixel value and
//           its linear index, out_tlast marks the last pixel of the byte's
//           run, out_tuser[0] marks the pixel that fills the image.
//   cfg_* : cfg_we writes cfg_wdata as the image pixel count; write only idle.
// Timing: the byte (or run's value byte) is taken, the controller enters
//   its emit state, then each pixel is loaded into the output register. A
//   count byte only loads the run length. Run expansion is paced by the single
//   output register, one pixel per cycle while out_tready is high.
// Reset: rst_n (synchronous, low) clears the pixel counter and run state
//   and sets the pixel count to 64000. After the count is reached every
//   byte is taken and dropped until reset.
// Stall: while out_tready is low the output register holds its beat; a run
//   pauses, and in_tready stays low until the run has been emitted.
`timescale 1ns / 1ps

module pcx_rle_decoder #(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] pixel_value, [27:8] pixel_index, [31:28] zero
  output logic        out_tlast,   // run_last
  output logic [0:0]  out_tuser,   // [0] image_done
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata    // image_pixels
);

  pcxrle_pkg::ctl_cmd_t cmd;
  pcxrle_pkg::dp_sts_t  sts;

  logic [pcxrle_pkg::BYTE_W-1:0] pix_value;
  logic [pcxrle_pkg::IDX_W-1:0]  pix_index;
  logic                          pix_done;

  pcxrle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcxrle_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (pix_value),
    .out_index  (pix_index),
    .out_last   (out_tlast),
    .out_done   (pix_done)
  );

  // Pack result beat
  assign out_tdata = {4'b0, pix_index, pix_value};
  assign out_tuser = pix_done;

endmodule

[sv/pcxrle_ctrl.sv]
// Controller state machine of the PCX run-length decoder.
`timescale 1ns / 1ps
`include "pcx_rle_decoder_macros.svh"

module pcxrle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pcxrle_pkg::dp_sts_t sts,
  output pcxrle_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take input only between runs
  assign in_tready  = (state_r == ST_IDLE);
  assign cmd.accept = in_tvalid && (state_r == ST_IDLE);
  assign cmd.emit   = (state_r == ST_EMIT) && sts.slot_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.start_run) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.emit && sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PCX_ASSERT_NOW(a_no_emit_while_ready, in_tready, !cmd.emit, "pixel emitted while taking input")
  `PCX_ASSERT_NEXT(a_last_ends_run, cmd.emit && sts.emit_last, in_tready, "run did not end on last pixel")

endmodule

[sv/pcxrle_dp.sv]
// Datapath of the PCX run-length decoder: run state, pixel counter, output register.
`timescale 1ns / 1ps
`include "pcx_rle_decoder_macros.svh"

module pcxrle_dp #(
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pcxrle_pkg::ctl_cmd_t                cmd,
  output pcxrle_pkg::dp_sts_t                 sts,
  input  logic [pcxrle_pkg::BYTE_W-1:0]       in_byte,
  input  logic                                cfg_we,
  input  logic [pcxrle_pkg::CNT_W-1:0]        cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pcxrle_pkg::BYTE_W-1:0]       out_value,
  output logic [pcxrle_pkg::IDX_W-1:0]        out_index,
  output logic                                out_last,
  output logic                                out_done
);

  localparam int unsigned MAXW_W = 25;
  localparam logic [MAXW_W-1:0] MAX_W = MAXW_W'(MAX_PIXELS);

  logic [pcxrle_pkg::CNT_W-1:0]  img_pix_r, img_pix_nxt;
  logic                          awaiting_r, awaiting_nxt;
  logic [pcxrle_pkg::RUN_W-1:0]  run_len_r, run_len_nxt;
  logic [pcxrle_pkg::CNT_W-1:0]  pix_cnt_r, pix_cnt_nxt;
  logic [pcxrle_pkg::RUN_W-1:0]  rem_r, rem_nxt;
  logic [pcxrle_pkg::BYTE_W-1:0] value_r, value_nxt;
  logic                          ovalid_r, ovalid_nxt;
  logic [pcxrle_pkg::BYTE_W-1:0] ovalue_r, ovalue_nxt;
  logic [pcxrle_pkg::IDX_W-1:0]  oindex_r, oindex_nxt;
  logic                          olast_r, olast_nxt;
  logic                          odone_r, odone_nxt;

  logic [pcxrle_pkg::CNT_W-1:0]  limit;
  logic [pcxrle_pkg::CNT_W:0]    cnt_inc;
  logic                          img_full;
  logic                          at_end;
  logic                          is_count;
  logic [pcxrle_pkg::RUN_W-1:0]  byte_len;

  // Effective limit: smaller of the register and the build maximum
  assign limit = ({4'b0, img_pix_r} > MAX_W) ? MAX_W[pcxrle_pkg::CNT_W-1:0] : img_pix_r;

  assign img_full = (pix_cnt_r >= limit);
  assign cnt_inc  = {1'b0, pix_cnt_r} + {{pcxrle_pkg::CNT_W{1'b0}}, 1'b1};
  assign at_end   = (cnt_inc >= {1'b0, limit});
  assign is_count = ((in_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK);
  assign byte_len = pcxrle_pkg::RUN_W'(in_byte & pcxrle_pkg::RUN_MASK);

  // Status to the controller
  assign sts.slot_free = !ovalid_r || out_tready;
  assign sts.emit_last = (rem_r == pcxrle_pkg::RUN_W'(1)) || at_end;
  assign sts.start_run = !img_full && (awaiting_r ? (run_len_r != '0) : !is_count);

  // Decode accepted beat, step the run
  always_comb begin
    img_pix_nxt  = img_pix_r;
    awaiting_nxt = awaiting_r;
    run_len_nxt  = run_len_r;
    pix_cnt_nxt  = pix_cnt_r;
    rem_nxt      = rem_r;
    value_nxt    = value_r;
    if (cfg_we) begin
      img_pix_nxt = cfg_wdata;
    end
    if (cmd.accept && !img_full) begin
      if (awaiting_r) begin
        awaiting_nxt = 1'b0;
        run_len_nxt  = '0;
        rem_nxt      = run_len_r;
        value_nxt    = in_byte;
      end else if (is_count) begin
        awaiting_nxt = 1'b1;
        run_len_nxt  = byte_len;
      end else begin
        rem_nxt   = pcxrle_pkg::RUN_W'(1);
        value_nxt = in_byte;
      end
    end
    if (cmd.emit) begin
      pix_cnt_nxt = cnt_inc[pcxrle_pkg::CNT_W-1:0];
      rem_nxt     = rem_r - pcxrle_pkg::RUN_W'(1);
    end
  end

  // Output register: load on emit, drop when taken
  always_comb begin
    ovalid_nxt = ovalid_r;
    ovalue_nxt = ovalue_r;
    oindex_nxt = oindex_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      ovalue_nxt = value_r;
      oindex_nxt = pix_cnt_r[pcxrle_pkg::IDX_W-1:0];
      olast_nxt  = sts.emit_last;
      odone_nxt  = at_end;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_pix_r  <= pcxrle_pkg::IMG_PIX_RESET;
      awaiting_r <= 1'b0;
      run_len_r  <= '0;
      pix_cnt_r  <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      img_pix_r  <= img_pix_nxt;
      awaiting_r <= awaiting_nxt;
      run_len_r  <= run_len_nxt;
      pix_cnt_r  <= pix_cnt_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    value_r  <= value_nxt;
    ovalue_r <= ovalue_nxt;
    oindex_r <= oindex_nxt;
    olast_r  <= olast_nxt;
    odone_r  <= odone_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_value  = ovalue_r;
  assign out_index  = oindex_r;
  assign out_last   = olast_r;
  assign out_done   = odone_r;

  `PCX_ASSERT_NOW(a_done_ends_run, ovalid_r && odone_r, olast_r, "final pixel not marked last")
  `PCX_ASSERT_NEXT(a_emit_counts, cmd.emit, pix_cnt_r == $past(pix_cnt_r) + 21'd1, "counter did not advance")

endmodule
